FILE: src/phb_pkg.sv
// ---------------------------------------------------------------------------
// phb_pkg
// Shared constants, controller states and the command and status groups of
// the polynomial string hash bucket core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package phb_pkg;

  localparam logic [29:0] HASH_PRIME = 30'd1000000007;
  localparam logic [8:0]  HASH_BASE  = 9'd263;
  // 2^30 mod HASH_PRIME, used to fold the bits above bit 29 back down.
  localparam logic [26:0] FOLD_C     = 27'd73741817;
  localparam int          SUM_BITS   = 30;
  localparam logic [4:0]  DIV_STEPS  = 5'd30;
  localparam int          CFG_BITS   = 21;
  localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 21'd5;
  localparam logic        REG_BUCKET_COUNT = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD1,
    ST_FOLD2,
    ST_FIX,
    ST_ACC,
    ST_DIV
  } phb_state_t;

  typedef struct packed {
    logic load_prod;
    logic fix_en;
    logic acc_en;
    logic div_step;
    logic out_load;
  } phb_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_free;
  } phb_status_t;

endpackage

`default_nettype wire

FILE: src/phb_ifs.sv
// ---------------------------------------------------------------------------
// phb_ifs
// Request channels of the hash core: key characters in, bucket indexes out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface phb_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_char;
  logic       is_last;

  modport source (output valid, output key_char, output is_last, input ready);
  modport sink   (input valid, input key_char, input is_last, output ready);
endinterface

interface phb_bucket_if #(
  parameter int BUCKET_BITS = 20
);
  logic                   valid;
  logic                   ready;
  logic [BUCKET_BITS-1:0] bucket_index;

  modport source (output valid, output bucket_index, input ready);
  modport sink   (input valid, input bucket_index, output ready);
endinterface

`default_nettype wire

FILE: src/polynomial_string_hash_bucket_core.sv
// ---------------------------------------------------------------------------
// polynomial_string_hash_bucket_core
// Polynomial rolling hash of a key string modulo 1000000007 with base 263,
// reduced to a bucket index by the configured bucket count.
// ---------------------------------------------------------------------------
// Within a key each character passes through two constant folds, a final
// correction and the accumulate step of the modular datapath, in which the next
// character may enter. On a last character the 30-step restoring divider
// sets the index, which waits for a free output register; the next key follows.
// Reset (synchronous, active high) sets the sum to 0, the power to 1, the
// bucket count to 5 and empties the output register, all at once.
`timescale 1ns / 1ps
`default_nettype none

module polynomial_string_hash_bucket_core #(
  parameter int BUCKET_BITS = 20
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          psel,
  input  wire          penable,
  input  wire          pwrite,
  input  wire [2:0]    paddr,
  input  wire [31:0]   pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  phb_key_if.sink      key_in,
  phb_bucket_if.source bucket_out
);
  import phb_pkg::*;

  logic [CFG_BITS-1:0] bucket_count;
  phb_cmd_t            cmd;
  phb_status_t         status;
  logic                in_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= BUCKET_COUNT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BUCKET_COUNT)) begin
      bucket_count <= pwdata[CFG_BITS-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_BUCKET_COUNT) begin
      prdata = 32'(bucket_count);
    end else begin
      prdata = '0;
    end
  end

  assign key_in.ready = in_ready;

  phb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (key_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  phb_datapath #(
    .BUCKET_BITS (BUCKET_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .key_char     (key_in.key_char),
    .is_last      (key_in.is_last),
    .bucket_count (bucket_count),
    .out_ready    (bucket_out.ready),
    .out_valid    (bucket_out.valid),
    .bucket_index (bucket_out.bucket_index)
  );

endmodule

`default_nettype wire

FILE: src/phb_ctrl.sv
// ---------------------------------------------------------------------------
// phb_ctrl
// Sequencer that steps each character through the modular reduction and
// runs the final bucket division at the end of a key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phb_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  phb_pkg::phb_status_t status,
  output phb_pkg::phb_cmd_t    cmd
);
  import phb_pkg::*;

  phb_state_t state;
  phb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_prod = 1'b1;
          state_next    = ST_FOLD1;
        end
      end
      ST_FOLD1: state_next = ST_FOLD2;
      ST_FOLD2: state_next = ST_FIX;
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_en = 1'b1;
        if (status.last) begin
          state_next = ST_DIV;
        end else begin
          // The power is already updated, so the next character may enter.
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load_prod = 1'b1;
            state_next    = ST_FOLD1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done && status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/phb_datapath.sv
// ---------------------------------------------------------------------------
// phb_datapath
// Running sum and power modulo the prime, the restoring divider for the
// bucket reduction and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phb_datapath #(
  parameter int BUCKET_BITS = 20
) (
  input  wire                                clk,
  input  wire                                rst,
  input  phb_pkg::phb_cmd_t                  cmd,
  output phb_pkg::phb_status_t               status,
  input  wire [7:0]                          key_char,
  input  wire                                is_last,
  input  wire [phb_pkg::CFG_BITS-1:0]        bucket_count,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [BUCKET_BITS-1:0]             bucket_index
);
  import phb_pkg::*;

  localparam int CW = (BUCKET_BITS + 1 > CFG_BITS) ? BUCKET_BITS + 1 : CFG_BITS;
  localparam logic [CW-1:0] LIMIT = CW'(1) << BUCKET_BITS;
  localparam logic [31:0] PRIME_X1 = {2'b00, HASH_PRIME};
  localparam logic [31:0] PRIME_X2 = {1'b0, HASH_PRIME, 1'b0};

  function automatic logic [34:0] fold_hi(input logic [38:0] x);
    fold_hi = 35'(x[38:30]) * 35'(FOLD_C) + 35'(x[29:0]);
  endfunction

  function automatic logic [31:0] fold_lo(input logic [34:0] y);
    fold_lo = 32'(y[34:30]) * 32'(FOLD_C) + 32'(y[29:0]);
  endfunction

  // The value is below three times the prime after two folds.
  function automatic logic [29:0] fix_mod(input logic [31:0] z);
    logic [31:0] r;
    if (z >= PRIME_X2) begin
      r = z - PRIME_X2;
    end else if (z >= PRIME_X1) begin
      r = z - PRIME_X1;
    end else begin
      r = z;
    end
    fix_mod = r[29:0];
  endfunction

  logic [SUM_BITS-1:0] running_sum;
  logic [SUM_BITS-1:0] running_power;
  logic                last;
  logic [38:0]         prod_term;
  logic [38:0]         prod_power;
  logic [34:0]         fold1_term;
  logic [34:0]         fold1_power;
  logic [31:0]         fold2_term;
  logic [31:0]         fold2_power;
  logic [SUM_BITS-1:0] term;

  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_next;

  logic [SUM_BITS-1:0]    dividend;
  logic [BUCKET_BITS-1:0] remainder;
  logic [BUCKET_BITS:0]   divisor;
  logic [4:0]             div_cnt;
  logic [BUCKET_BITS:0]   trial;
  logic [CW-1:0]          count_ext;
  logic [CW-1:0]          count_eff;

  always_comb begin
    sum_wide = {1'b0, running_sum} + {1'b0, term};
    if (sum_wide >= {1'b0, HASH_PRIME}) begin
      sum_next = SUM_BITS'(sum_wide - {1'b0, HASH_PRIME});
    end else begin
      sum_next = sum_wide[SUM_BITS-1:0];
    end
  end

  // A zero count acts as one bucket; a count beyond the field saturates.
  always_comb begin
    count_ext = CW'(bucket_count);
    if (count_ext == '0) begin
      count_eff = CW'(1);
    end else if (count_ext > LIMIT) begin
      count_eff = LIMIT;
    end else begin
      count_eff = count_ext;
    end
  end

  assign trial = {remainder, dividend[SUM_BITS-1]};

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod_term  <= 39'(key_char) * 39'(running_power);
      prod_power <= 39'(running_power) * 39'(HASH_BASE);
    end
    fold1_term  <= fold_hi(prod_term);
    fold1_power <= fold_hi(prod_power);
    fold2_term  <= fold_lo(fold1_term);
    fold2_power <= fold_lo(fold1_power);
    if (cmd.fix_en) begin
      term <= fix_mod(fold2_term);
    end
    if (cmd.acc_en && last) begin
      dividend  <= sum_next;
      remainder <= '0;
      divisor   <= count_eff[BUCKET_BITS:0];
    end else if (cmd.div_step && (div_cnt != DIV_STEPS)) begin
      dividend <= dividend << 1;
      if (trial >= divisor) begin
        remainder <= BUCKET_BITS'(trial - divisor);
      end else begin
        remainder <= trial[BUCKET_BITS-1:0];
      end
    end
    if (cmd.out_load) begin
      bucket_index <= remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum   <= '0;
      running_power <= SUM_BITS'(1);
      last          <= 1'b0;
      div_cnt       <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load_prod) begin
        last <= is_last;
      end
      if (cmd.fix_en) begin
        running_power <= last ? SUM_BITS'(1) : fix_mod(fold2_power);
      end
      if (cmd.acc_en) begin
        running_sum <= last ? '0 : sum_next;
      end
      if (cmd.acc_en && last) begin
        div_cnt <= '0;
      end else if (cmd.div_step && (div_cnt != DIV_STEPS)) begin
        div_cnt <= div_cnt + 5'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign status.last     = last;
  assign status.div_done = (div_cnt == DIV_STEPS);
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

FILE: src/phb_checker.sv
// ---------------------------------------------------------------------------
// phb_checker
// Port-level checks on the hash core's request channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module phb_checker #(
  parameter int BUCKET_BITS = 20
) (
  input wire                   clk,
  input wire                   rst,
  input wire                   in_valid,
  input wire                   in_ready,
  input wire                   out_valid,
  input wire                   out_ready,
  input wire [BUCKET_BITS-1:0] bucket_index
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bucket_index))
    else $error("bucket index changed or dropped while stalled");

  // Each character occupies the datapath, so two characters are never taken back to back.
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in consecutive cycles");

  // A result appears only from the divider, while input is held off.
  a_result_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while input was open");

  // A character just taken cannot produce a result in the next cycle.
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after a character");

endmodule

bind polynomial_string_hash_bucket_core phb_checker #(
  .BUCKET_BITS (BUCKET_BITS)
) u_phb_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (key_in.valid),
  .in_ready     (key_in.ready),
  .out_valid    (bucket_out.valid),
  .out_ready    (bucket_out.ready),
  .bucket_index (bucket_out.bucket_index)
);

`default_nettype wire

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the polynomial string hash bucket core. Keys go in
// one character per request and bucket indexes are checked against a local
// model of the rolling hash under several bucket counts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import phb_pkg::*;

  localparam int          BUCKET_BITS = 20;
  localparam logic [63:0] MOD_PRIME   = 64'd1000000007;
  localparam logic [63:0] ROLL_BASE   = 64'd263;
  localparam logic [2:0]  BUCKET_COUNT_ADDR = {REG_BUCKET_COUNT, 2'b00};
  localparam int          IDLE_LIMIT  = 3000;
  localparam int          SETTLE_CYCLES = 50;
  localparam int          LONG_HOLD   = 400;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } key_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  phb_key_if                                   key_if ();
  phb_bucket_if #(.BUCKET_BITS(BUCKET_BITS))   bucket_if ();

  polynomial_string_hash_bucket_core #(.BUCKET_BITS(BUCKET_BITS)) DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .key_in     (key_if),
    .bucket_out (bucket_if)
  );

  always #5 clk = ~clk;

  // Local copy of the hash state and the bucket count.
  logic [29:0]            hash_sum = 30'd0;
  logic [29:0]            hash_pow = 30'd1;
  logic [20:0]            cfg_bucket_count = 21'd5;
  key_item_t              key_backlog[$];
  logic [BUCKET_BITS-1:0] bucket_due[$];
  logic                   steady = 1'b0;
  int                     key_gap = 0;
  int                     ready_gap = 0;
  int                     hold_left = 0;
  int                     buckets_seen = 0;
  int                     fail_count = 0;
  int                     idle_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic void queue_key(input logic [7:0] ch, input logic last);
    key_item_t req;
    req.ch      = ch;
    req.last    = last;
    key_backlog = {key_backlog, req};
  endfunction

  // Folds one character into the running hash; a last character closes the
  // key and queues the bucket index it maps to.
  function automatic void hash_absorb(input logic [7:0] ch, input logic last);
    logic [63:0] term;
    logic [63:0] buckets;
    term     = (64'(ch) * 64'(hash_pow)) % MOD_PRIME;
    hash_sum = 30'((64'(hash_sum) + term) % MOD_PRIME);
    hash_pow = 30'((64'(hash_pow) * ROLL_BASE) % MOD_PRIME);
    if (last) begin
      buckets = (cfg_bucket_count == 21'd0) ? 64'd1 : 64'(cfg_bucket_count);
      if (buckets > (64'd1 << BUCKET_BITS)) buckets = 64'd1 << BUCKET_BITS;
      bucket_due = {bucket_due, BUCKET_BITS'(64'(hash_sum) % buckets)};
      hash_sum = 30'd0;
      hash_pow = 30'd1;
    end
  endfunction

  task automatic write_bucket_count(input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BUCKET_COUNT_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_bucket_count = value[20:0];
  endtask

  // Waits until every request is taken and every bucket index has come back,
  // then lets the core finish any work still in flight.
  task automatic drain();
    do @(negedge clk);
    while (key_backlog.size() != 0 || key_if.valid || bucket_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : key_driver
    key_item_t nxt;
    if (rst) begin
      key_if.valid <= 1'b0;
      key_gap = 0;
    end else begin
      if (key_if.valid && key_if.ready) begin
        hash_absorb(key_if.key_char, key_if.is_last);
        key_gap = steady ? 0 : pick_gap();
      end
      if (!key_if.valid || key_if.ready) begin
        if (key_gap > 0) begin
          key_gap--;
          key_if.valid <= 1'b0;
        end else if (key_backlog.size() != 0) begin
          nxt = key_backlog.pop_front();
          key_if.valid    <= 1'b1;
          key_if.key_char <= nxt.ch;
          key_if.is_last  <= nxt.last;
        end else begin
          key_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : bucket_monitor
    logic [BUCKET_BITS-1:0] want;
    logic                   rdy;
    if (rst) begin
      bucket_if.ready <= 1'b0;
    end else begin
      if (bucket_if.valid && bucket_if.ready) begin
        if (bucket_due.size() == 0) begin
          $error("bucket_index: expected none, got %0d", bucket_if.bucket_index);
          fail_count++;
        end else begin
          want = bucket_due.pop_front();
          if (bucket_if.bucket_index !== want) begin
            $error("bucket_index: expected %0d, got %0d", want, bucket_if.bucket_index);
            fail_count++;
          end
        end
        buckets_seen++;
        // A long hold-off lets the core fill up and push back on the sender.
        if (buckets_seen == 25 || buckets_seen == 60) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (steady) begin
        rdy = 1'b1;
      end else if (ready_gap > 0) begin
        ready_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        ready_gap = pick_gap();
      end
      bucket_if.ready <= rdy;
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (key_if.valid && key_if.ready) || (bucket_if.valid && bucket_if.ready)
        || (psel && penable && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          len;
    int          chars;
    int          r;
    logic [31:0] val;
    key_if.valid     = 1'b0;
    key_if.key_char  = 8'd0;
    key_if.is_last   = 1'b0;
    bucket_if.ready  = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Bucket count still at its reset value.
    queue_key(8'd0, 1'b1);
    queue_key(8'd255, 1'b1);
    queue_key(8'd255, 1'b0);
    queue_key(8'd255, 1'b0);
    queue_key(8'd255, 1'b1);
    queue_key(8'd0, 1'b0);
    queue_key(8'd0, 1'b0);
    queue_key(8'd1, 1'b1);
    drain();

    // A zero bucket count acts as a single bucket.
    write_bucket_count(32'd0);
    queue_key(8'd200, 1'b1);
    queue_key(8'd17, 1'b0);
    queue_key(8'd42, 1'b1);
    drain();

    // Counts above the index range saturate to 2^BUCKET_BITS.
    write_bucket_count(32'h001F_FFFF);
    for (int i = 0; i < 4; i++) queue_key(8'd255, i == 3);
    drain();

    write_bucket_count(32'd1048577);
    queue_key(8'd1, 1'b0);
    queue_key(8'd2, 1'b0);
    queue_key(8'd3, 1'b1);
    drain();

    write_bucket_count(32'd1);
    queue_key(8'd99, 1'b1);
    drain();

    // An all-zero key hashes to zero.
    write_bucket_count(32'd7);
    for (int i = 0; i < 3; i++) queue_key(8'd0, i == 2);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       val = 32'd1048576;
        1:       val = $urandom_range(1, 64);
        2:       val = $urandom_range(2, 1048576);
        3:       val = 32'h001F_FFFF;
        4:       val = 32'd1048575;
        5:       val = $urandom;
        default: val = 32'd0;
      endcase
      write_bucket_count(val);
      steady = (p == 3);
      chars = 0;
      while (chars < 175) begin
        r = $urandom_range(0, 99);
        if (r < 80) len = $urandom_range(1, 6);
        else if (r < 97) len = $urandom_range(7, 30);
        else len = $urandom_range(31, 120);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          queue_key((r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(0, 255)),
                    i == len - 1);
        end
        chars += len;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/phb_pkg.sv
src/phb_ifs.sv
src/phb_ctrl.sv
src/phb_datapath.sv
src/polynomial_string_hash_bucket_core.sv
src/phb_checker.sv
dv/tb.sv
